// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the range minimum tree blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// Range minimum tree package
// Field widths, request codes, the sentinel and the controller/datapath types.
// ----------------------------------------------------------------------------
package rmst_pkg;

   localparam int POS_W   = 10;
   localparam int VALUE_W = 31;

   localparam logic [VALUE_W-1:0] SENTINEL = 31'h7FFF_FFFF;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef logic [VALUE_W-1:0] value_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic load_upd;
      logic load_qry;
      logic upd_leaf;
      logic upd_walk;
      logic qry_walk;
      logic rsp_load;
   } rmst_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic pos_ok;
      logic upd_top;
      logic qry_drained;
      logic rsp_free;
   } rmst_status_type;

   function automatic value_type val_min(input value_type a, input value_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ===== rtl/core/rmst_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rmst_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     ra_en,
   input  logic [$clog2(DEPTH)-1:0] ra_addr,
   output logic [WIDTH-1:0]         ra_data,
   input  logic                     rb_en,
   input  logic [$clog2(DEPTH)-1:0] rb_addr,
   output logic [WIDTH-1:0]         rb_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] ra_data_ff;
   logic [WIDTH-1:0] rb_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (ra_en) begin
         ra_data_ff <= mem_ff[ra_addr];
      end
      if (rb_en) begin
         rb_data_ff <= mem_ff[rb_addr];
      end
   end

   assign ra_data = ra_data_ff;
   assign rb_data = rb_data_ff;

endmodule

// ===== rtl/core/rmst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Range minimum tree controller
// Sequences the clearing pass, the update walk and the query walk.
// ----------------------------------------------------------------------------
module rmst_ctrl import rmst_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_type,
   input  rmst_status_type status_i,
   output rmst_cmd_type    cmd_o
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ULEAF = 5'b00100,
      ST_UWALK = 5'b01000,
      ST_QWALK = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd_o.clear_en = 1'b1;
            if (status_i.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_QUERY) begin
                  cmd_o.load_qry = 1'b1;
                  state_in       = ST_QWALK;
               end else if (status_i.pos_ok) begin
                  cmd_o.load_upd = 1'b1;
                  state_in       = ST_ULEAF;
               end
            end
         end
         ST_ULEAF: begin
            cmd_o.upd_leaf = 1'b1;
            state_in       = ST_UWALK;
         end
         ST_UWALK: begin
            cmd_o.upd_walk = 1'b1;
            if (status_i.upd_top) begin
               state_in = ST_IDLE;
            end
         end
         ST_QWALK: begin
            cmd_o.qry_walk = 1'b1;
            if (status_i.qry_drained && status_i.rsp_free) begin
               cmd_o.rsp_load = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/rmst_datapath.sv =====
// ----------------------------------------------------------------------------
// Range minimum tree datapath
// Node memory, walk index registers, running minimum and result register.
// ----------------------------------------------------------------------------
module rmst_datapath import rmst_pkg::*; #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  rmst_cmd_type       cmd_i,
   output rmst_status_type    status_o,
   input  logic [POS_W-1:0]   req_position,
   input  logic [VALUE_W-1:0] req_new_value,
   input  logic [POS_W-1:0]   req_range_first,
   input  logic [POS_W-1:0]   req_range_last,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_range_minimum
);

   localparam int DEPTH = 2 * LEAF_COUNT;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(DEPTH + 1);
   localparam int CW    = (IW > POS_W) ? IW : POS_W;

   localparam logic [CW-1:0] LEAF_C = CW'(LEAF_COUNT);
   localparam logic [CW-1:0] LAST_C = CW'(LEAF_COUNT - 1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

   // Walk registers.
   logic [AW-1:0]  clr_ff, clr_in;
   logic [AW-1:0]  node_ff, node_in;
   value_type      cur_ff, cur_in;
   logic [IW-1:0]  lo_ff, lo_in;
   logic [IW-1:0]  hi_ff, hi_in;
   logic           pend_a_ff, pend_a_in;
   logic           pend_b_ff, pend_b_in;
   value_type      acc_ff, acc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   value_type      rsp_min_ff, rsp_min_in;

   // Memory ports.
   logic           we;
   logic [AW-1:0]  waddr;
   value_type      wdata;
   logic           ra_en, rb_en;
   logic [AW-1:0]  ra_addr, rb_addr;
   value_type      ra_data, rb_data;

   // Request decode.
   logic [CW-1:0]  pos_ext, first_ext, last_ext, last_clamp;
   logic [CW-1:0]  leaf_idx, lo_start, hi_start;
   logic           q_empty;

   logic [AW-1:0]  parent;
   logic [IW-1:0]  hi_dec;
   logic           walk_live;
   value_type      upd_min;
   value_type      a_term, b_term;

   assign pos_ext    = CW'(req_position);
   assign first_ext  = CW'(req_range_first);
   assign last_ext   = CW'(req_range_last);
   assign last_clamp = (last_ext >= LEAF_C) ? LAST_C : last_ext;
   assign q_empty    = (first_ext >= LEAF_C) || (first_ext > last_clamp);
   assign leaf_idx   = pos_ext + LEAF_C;
   assign lo_start   = first_ext + LEAF_C;
   assign hi_start   = last_clamp + LEAF_C + CW'(1);

   assign parent    = {1'b0, node_ff[AW-1:1]};
   assign upd_min   = val_min(cur_ff, ra_data);
   assign walk_live = (lo_ff < hi_ff);
   assign hi_dec    = hi_ff - IW'(1);
   assign a_term    = pend_a_ff ? ra_data : SENTINEL;
   assign b_term    = pend_b_ff ? rb_data : SENTINEL;

   always_comb begin
      we      = 1'b0;
      waddr   = node_ff;
      wdata   = cur_ff;
      ra_en   = 1'b0;
      ra_addr = {node_ff[AW-1:1], ~node_ff[0]};
      rb_en   = 1'b0;
      rb_addr = hi_dec[AW-1:0];

      clr_in  = clr_ff;
      node_in = node_ff;
      cur_in  = cur_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      pend_a_in = 1'b0;
      pend_b_in = 1'b0;
      acc_in  = val_min(acc_ff, val_min(a_term, b_term));

      if (cmd_i.clear_en) begin
         we     = 1'b1;
         waddr  = clr_ff;
         wdata  = SENTINEL;
         clr_in = clr_ff + AW'(1);
      end

      if (cmd_i.load_upd) begin
         node_in = leaf_idx[AW-1:0];
         cur_in  = req_new_value;
      end

      if (cmd_i.load_qry) begin
         acc_in = SENTINEL;
         if (q_empty) begin
            lo_in = '0;
            hi_in = '0;
         end else begin
            lo_in = lo_start[IW-1:0];
            hi_in = hi_start[IW-1:0];
         end
      end

      // Leaf write, with the sibling read issued alongside.
      if (cmd_i.upd_leaf) begin
         we    = 1'b1;
         ra_en = 1'b1;
      end

      // One level a cycle: the sibling read of the previous cycle returns,
      // the parent is written and the parent's sibling is read.
      if (cmd_i.upd_walk) begin
         we      = 1'b1;
         waddr   = parent;
         wdata   = upd_min;
         cur_in  = upd_min;
         node_in = parent;
         ra_en   = 1'b1;
         ra_addr = {parent[AW-1:1], ~parent[0]};
      end

      // One level a cycle: the odd left bound and the node below an odd right
      // bound are fetched on the two read ports, then both bounds move up a level.
      if (cmd_i.qry_walk && walk_live) begin
         ra_en     = lo_ff[0];
         ra_addr   = lo_ff[AW-1:0];
         rb_en     = hi_ff[0];
         pend_a_in = lo_ff[0];
         pend_b_in = hi_ff[0];
         lo_in     = (lo_ff + IW'(lo_ff[0])) >> 1;
         hi_in     = (hi_ff - IW'(hi_ff[0])) >> 1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_min_in   = rsp_min_ff;
      if (cmd_i.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_min_in   = acc_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         pend_a_ff    <= 1'b0;
         pend_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         pend_a_ff    <= pend_a_in;
         pend_b_ff    <= pend_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      cur_ff     <= cur_in;
      acc_ff     <= acc_in;
      rsp_min_ff <= rsp_min_in;
   end

   rmst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .ra_en   (ra_en),
      .ra_addr (ra_addr),
      .ra_data (ra_data),
      .rb_en   (rb_en),
      .rb_addr (rb_addr),
      .rb_data (rb_data)
   );

   assign status_o.clear_last  = (clr_ff == ADDR_LAST);
   assign status_o.pos_ok      = (pos_ext < LEAF_C);
   assign status_o.upd_top     = (parent == AW'(1));
   assign status_o.qry_drained = !walk_live && !pend_a_ff && !pend_b_ff;
   assign status_o.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_minimum = rsp_min_ff;

endmodule

// ===== rtl/core/range_min_segment_tree_unit.sv =====
// ----------------------------------------------------------------------------
// Range minimum segment tree unit
// Bottom-up min-tree over LEAF_COUNT positions with point update and
// inclusive range minimum query.
// ----------------------------------------------------------------------------
// The tree lives in one RAM of 2*LEAF_COUNT nodes with one write port and two
// registered read ports; leaves sit at LEAF_COUNT and up, and every inner node
// holds the minimum of its two children. After reset the unit runs a clearing
// pass that writes the sentinel 2147483647 into every node, and req_ready
// stays low until it is done. An update transaction is then accepted, writes
// the leaf and walks up one level per cycle, where each level reads the
// sibling on one RAM port and writes the parent, so the walk is paced by the
// registered RAM read. A query transaction is accepted, then both bounds
// climb one level per cycle and fetch the odd left node and the node below
// an odd right bound on the two read ports, the last returned data is folded
// in, and the minimum is handed to the result register once it is free.
// Updates with a position past the tree are taken and dropped. A query whose
// range is empty, reversed or starts past the tree answers the sentinel; a
// range end past the tree is clamped to the last position. Updates give no
// result transaction. The unit works on one transaction at a time, but a
// finished result waits in its own register, so the next request is taken
// while the previous result is still held on the rsp_ channel.
// ----------------------------------------------------------------------------
module range_min_segment_tree_unit import rmst_pkg::*; #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [POS_W-1:0]   req_position,
   input  logic [VALUE_W-1:0] req_new_value,
   input  logic [POS_W-1:0]   req_range_first,
   input  logic [POS_W-1:0]   req_range_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_range_minimum
);

   rmst_cmd_type    cmd;
   rmst_status_type status;

   // The controller owns the sequencing and the request handshake.
   rmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   // The datapath holds the node memory, the walk indexes and the result.
   rmst_datapath #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd_i             (cmd),
      .status_o          (status),
      .req_position      (req_position),
      .req_new_value     (req_new_value),
      .req_range_first   (req_range_first),
      .req_range_last    (req_range_last),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_range_minimum (rsp_range_minimum)
   );

`include "assert_macros.svh"

   // No request may be taken while the clearing pass is still writing nodes.
   `ASSERT_IMPLIES(a_clear_blocks_req, clock, reset, cmd.clear_en, !req_ready, "request taken during clearing pass")

   // A new result is only loaded when the result register is free.
   `ASSERT_IMPLIES(a_rsp_load_free, clock, reset, cmd.rsp_load, !rsp_valid || rsp_ready, "result overwritten before it was taken")

   // An accepted update never brings up a result in the next cycle.
   `ASSERT_NEXT(a_update_silent, clock, reset, req_valid && req_ready && (req_type == REQ_UPDATE), !$rose(rsp_valid), "update produced a result")

endmodule
